[rtl/core/fbl_pkg.sv]
// Package for the amplifier current foldback limiter: widths, reset values,
// register index codes and the structs passed between the modules.
// No dependencies.
package fbl_pkg;

	// Width of the budget timer.
	localparam int TIMER_BITS = 16;
	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam int PROD_W = 24 + TIMER_BITS;
	localparam int CAP_W = ((PROD_W > 31) ? PROD_W : 31) + 1;
	localparam longint TIMER_MAX_L = (longint'(1) << TIMER_BITS) - 1;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 32;

	// Register reset values.
	localparam logic [14:0] CONT_RST = 15'd2560;
	localparam logic [14:0] PEAK_RST = 15'd5120;
	localparam logic [15:0] BUDGET_RST = 16'd3000;
	localparam logic [23:0] SLOPE_RST = 24'd65536;
	localparam logic [23:0] GAIN_RST = 24'd4096;
	localparam logic [14:0] CEIL_RST = 15'd8192;
	localparam logic LIMIT_EN_RST = 1'b0;

	// State reset values follow from the register reset values.
	localparam longint TIMER_RST_L = (longint'(BUDGET_RST) < TIMER_MAX_L) ?
		longint'(BUDGET_RST) : TIMER_MAX_L;
	localparam logic [TIMER_BITS-1:0] TIMER_RST = TIMER_BITS'(TIMER_RST_L);
	localparam logic [31:0] LEVEL_RST = {1'b0, CEIL_RST, 16'd0};

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CONTINUOUS = 3'd0,
		REG_PEAK       = 3'd1,
		REG_BUDGET     = 3'd2,
		REG_SLOPE      = 3'd3,
		REG_GAIN       = 3'd4,
		REG_CEILING    = 3'd5,
		REG_ENABLE     = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [14:0] continuous_current;
		logic [14:0] peak_current;
		logic [15:0] budget_ticks;
		logic [23:0] slope_per_tick;
		logic [23:0] recovery_gain;
		logic [14:0] counter_ceiling;
		logic        limit_enable;
	} cfg_t;

	typedef struct packed {
		logic               amp_enabled;
		logic signed [15:0] target_current;
	} item_t;

	typedef struct packed {
		logic               foldback_active;
		logic [14:0]        present_limit;
		logic signed [15:0] drive_current;
	} result_t;

endpackage

[rtl/core/fbl_cfg.sv]
// Configuration register file of the foldback limiter.
// Depends on fbl_pkg for the register index codes and the cfg_t struct.
module fbl_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output fbl_pkg::cfg_t                  cfg
);

	fbl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.continuous_current <= fbl_pkg::CONT_RST;
			cfg_q.peak_current       <= fbl_pkg::PEAK_RST;
			cfg_q.budget_ticks       <= fbl_pkg::BUDGET_RST;
			cfg_q.slope_per_tick     <= fbl_pkg::SLOPE_RST;
			cfg_q.recovery_gain      <= fbl_pkg::GAIN_RST;
			cfg_q.counter_ceiling    <= fbl_pkg::CEIL_RST;
			cfg_q.limit_enable       <= fbl_pkg::LIMIT_EN_RST;
		end else if (cfg_we) begin
			unique case (fbl_pkg::reg_index_t'(cfg_index))
				fbl_pkg::REG_CONTINUOUS: cfg_q.continuous_current <= cfg_wdata[14:0];
				fbl_pkg::REG_PEAK:       cfg_q.peak_current       <= cfg_wdata[14:0];
				fbl_pkg::REG_BUDGET:     cfg_q.budget_ticks       <= cfg_wdata[15:0];
				fbl_pkg::REG_SLOPE:      cfg_q.slope_per_tick     <= cfg_wdata[23:0];
				fbl_pkg::REG_GAIN:       cfg_q.recovery_gain      <= cfg_wdata[23:0];
				fbl_pkg::REG_CEILING:    cfg_q.counter_ceiling    <= cfg_wdata[14:0];
				fbl_pkg::REG_ENABLE:     cfg_q.limit_enable       <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/fbl_estimator.sv]
// Foldback state (flag, level counter, budget timer, limit) and the per-tick
// update and output clamp. Depends on fbl_pkg for widths, reset values and structs.
module fbl_estimator (
	input  logic            clk,
	input  logic            arst_n,
	input  fbl_pkg::cfg_t   cfg,
	input  logic            advance,
	input  fbl_pkg::item_t  item,
	output fbl_pkg::result_t result
);

	logic                            flag_q;
	logic [31:0]                     level_q;
	logic [fbl_pkg::TIMER_BITS-1:0]  timer_q;
	logic [14:0]                     limit_q;

	logic signed [16:0]              cmd_ext;
	logic [16:0]                     mag;
	logic                            over;
	logic                            budget_low;
	logic                            flag_n;
	logic                            est_zero;
	logic [31:0]                     level_a;
	logic [31:0]                     level_b;
	logic [30:0]                     ic_ext;
	logic [30:0]                     ceil_ext;
	logic [17:0]                     est_ext;
	logic [17:0]                     diff;
	logic [39:0]                     rec_prod;
	logic [31:0]                     inc;
	logic [32:0]                     sum;
	logic [fbl_pkg::TIMER_BITS-1:0]  timer_n;
	logic [fbl_pkg::PROD_W-1:0]      cap_prod;
	logic [fbl_pkg::CAP_W-1:0]       cap;
	logic [fbl_pkg::CAP_W-17:0]      cap_hi;
	logic [15:0]                     level_hi;
	logic [14:0]                     lim0;
	logic [14:0]                     lim;
	logic signed [16:0]              lim_s;
	logic signed [16:0]              drive_ext;

	assign cmd_ext  = {item.target_current[15], item.target_current};
	assign mag      = cmd_ext[16] ? 17'(-cmd_ext) : 17'(cmd_ext);
	assign over     = mag > {2'b00, cfg.continuous_current};
	assign budget_low = fbl_pkg::CMP_W'(timer_q) < fbl_pkg::CMP_W'(cfg.budget_ticks);
	assign ic_ext   = {cfg.continuous_current, 16'd0};
	assign ceil_ext = {cfg.counter_ceiling, 16'd0};

	// Foldback entry and exit; entering with a budget not yet full reloads the counter.
	always_comb begin
		flag_n   = flag_q;
		est_zero = 1'b0;
		level_a  = level_q;
		if (!item.amp_enabled) begin
			flag_n   = 1'b0;
			est_zero = 1'b1;
		end else if (!flag_q && over) begin
			flag_n = 1'b1;
			if (budget_low) begin
				level_a = {1'b0, limit_q, 16'd0};
			end
		end else if (flag_q && !over) begin
			flag_n = 1'b0;
		end
	end

	assign est_ext  = est_zero ? 18'd0 : {{2{item.target_current[15]}}, item.target_current};
	assign diff     = {3'b000, cfg.continuous_current} - est_ext;
	assign rec_prod = 40'(cfg.recovery_gain) * 40'(diff[15:0]);
	assign inc      = (!diff[17] && diff != 18'd0) ? rec_prod[39:8] : 32'd0;
	assign sum      = {1'b0, level_a} + {1'b0, inc};

	always_comb begin
		level_b = level_a;
		timer_n = timer_q;
		if (flag_n) begin
			if (level_a > {1'b0, ic_ext}) begin
				level_b = (level_a > {8'd0, cfg.slope_per_tick}) ?
					level_a - {8'd0, cfg.slope_per_tick} : 32'd0;
			end else begin
				level_b = {1'b0, ic_ext};
			end
			if (timer_q != '0) begin
				timer_n = timer_q - 1'b1;
			end
		end else begin
			if (level_a < {1'b0, ceil_ext}) begin
				level_b = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end else begin
				level_b = {1'b0, ceil_ext};
			end
			if (budget_low && timer_q != fbl_pkg::TIMER_MAX) begin
				timer_n = timer_q + 1'b1;
			end
		end
	end

	// The floor of a minimum is the minimum of the floors, so the compares
	// work on the integer amp bits only.
	assign cap_prod = fbl_pkg::PROD_W'(cfg.slope_per_tick) * fbl_pkg::PROD_W'(timer_n);
	assign cap      = fbl_pkg::CAP_W'(ic_ext) + fbl_pkg::CAP_W'(cap_prod);
	assign cap_hi   = cap[fbl_pkg::CAP_W-1:16];
	assign level_hi = level_b[31:16];
	assign lim0     = (level_hi < {1'b0, cfg.peak_current}) ? level_hi[14:0] : cfg.peak_current;
	assign lim      = (cap_hi < (fbl_pkg::CAP_W-16)'(lim0)) ? cap_hi[14:0] : lim0;
	assign lim_s    = {2'b00, lim};

	always_comb begin
		drive_ext = cmd_ext;
		if (cfg.limit_enable) begin
			if (cmd_ext > lim_s) begin
				drive_ext = lim_s;
			end else if (cmd_ext < -lim_s) begin
				drive_ext = -lim_s;
			end
		end
	end

	assign result.drive_current   = drive_ext[15:0];
	assign result.present_limit   = lim;
	assign result.foldback_active = flag_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= 1'b0;
			level_q <= fbl_pkg::LEVEL_RST;
			timer_q <= fbl_pkg::TIMER_RST;
			limit_q <= fbl_pkg::PEAK_RST;
		end else if (advance) begin
			flag_q  <= flag_n;
			level_q <= level_b;
			timer_q <= timer_n;
			limit_q <= lim;
		end
	end

endmodule

[rtl/core/amplifier_current_foldback_limiter_core.sv]
// Amplifier current foldback limiter, top level.
// The result is combinational on the input stage register, valid in the cycle
// after the input transaction, and is registered in the output stage. One item
// per cycle while the output is not stalled; the state updates on each advance.
// A full input stage can be held while an earlier result waits downstream.
// Reset (arst_n, asynchronous): registers take their defaults, foldback clear,
// level counter at ceiling, budget full, limit at peak current, pipeline empty.
module amplifier_current_foldback_limiter_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fbl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] target_current, [16] amp_enabled, [23:17] zero
	input  logic [fbl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] drive_current, [30:16] present_limit, [31] foldback_active
	output logic [fbl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	fbl_pkg::cfg_t    cfg;
	fbl_pkg::item_t   item_s1;
	logic             valid_s1;
	fbl_pkg::result_t result;
	fbl_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	// The item in the input stage moves on whenever the output stage is free
	// or is emptied by a transaction in the same cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata[16:0];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	fbl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fbl_estimator u_estimator (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item    (item_s1),
		.result  (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for amplifier_current_foldback_limiter_core: a directed set of
// ticks and register writes, then randomised phases checked against a foldback predictor.
// Depends on fbl_pkg and the core RTL only.
module testbench;
	import fbl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int TICKS_PER_PHASE = 105;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		bit         is_write;
		reg_index_t reg_sel;
		logic [23:0] value;
		item_t      stim;
		bit         has_want;
		result_t    want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// [15:0] target_current, [16] amp_enabled, [23:17] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [15:0] drive_current, [30:16] present_limit, [31] foldback_active
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Shadow registers and foldback state of the predictor.
	cfg_t                  regs;
	logic                  fb_active;
	logic [31:0]           level_q24;
	logic [TIMER_BITS-1:0] budget_left;
	logic [15:0]           limit_q8;

	result_t     awaited_outputs[$];
	stim_row_t   directed_rows[$];
	int          fail_count = 0;
	int          results_seen = 0;
	int          ticks_sent = 0;
	int unsigned cycle_count = 0;
	bit          stalls_on = 1'b1;
	int          stall_left = 0;
	result_t     got_out;
	result_t     want_out;

	amplifier_current_foldback_limiter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// One 1 ms tick of the amplifier foldback model; updates the shadow state.
	function automatic result_t predict_foldback(item_t stim);
		int cmd;
		int est;
		int mag;
		int ic;
		int diff;
		int drive;
		int lim_i;
		longint unsigned ic_ext;
		longint unsigned ceil_ext;
		longint unsigned inc;
		longint unsigned sum;
		longint unsigned cap;
		longint unsigned pk;
		longint unsigned lim;
		result_t r;
		cmd = $signed(stim.target_current);
		est = cmd;
		mag = (cmd < 0) ? -cmd : cmd;
		ic = regs.continuous_current;
		ic_ext = longint'(ic) << 16;

		if (!stim.amp_enabled) begin
			fb_active = 1'b0;
			est = 0;
		end else if (!fb_active && mag > ic) begin
			fb_active = 1'b1;
			// Re-entering before the budget has refilled restarts from the last limit.
			if (budget_left < regs.budget_ticks)
				level_q24 = {limit_q8, 16'd0};
		end else if (fb_active && mag <= ic) begin
			fb_active = 1'b0;
		end

		if (fb_active) begin
			if (level_q24 > ic_ext)
				level_q24 = (level_q24 > regs.slope_per_tick) ?
					level_q24 - regs.slope_per_tick : 32'd0;
			else
				level_q24 = ic_ext[31:0];
			if (budget_left != 0)
				budget_left = budget_left - 1'b1;
		end else begin
			ceil_ext = longint'(regs.counter_ceiling) << 16;
			if (level_q24 < ceil_ext) begin
				diff = ic - est;
				if (diff > 0)
					inc = (longint'(regs.recovery_gain) * longint'(diff)) >> 8;
				else
					inc = 0;
				sum = level_q24 + inc;
				level_q24 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			end else begin
				level_q24 = ceil_ext[31:0];
			end
			if (budget_left < regs.budget_ticks && budget_left != {TIMER_BITS{1'b1}})
				budget_left = budget_left + 1'b1;
		end

		cap = ic_ext + longint'(regs.slope_per_tick) * longint'(budget_left);
		pk = longint'(regs.peak_current) << 16;
		lim = level_q24;
		if (cap < lim)
			lim = cap;
		if (pk < lim)
			lim = pk;
		limit_q8 = lim[31:16];

		drive = cmd;
		if (regs.limit_enable) begin
			lim_i = limit_q8;
			if (drive > lim_i)
				drive = lim_i;
			else if (drive < -lim_i)
				drive = -lim_i;
		end
		r.drive_current = 16'(drive);
		r.present_limit = limit_q8[14:0];
		r.foldback_active = fb_active;
		return r;
	endfunction

	function automatic stim_row_t reg_row(reg_index_t sel, logic [23:0] value);
		stim_row_t row;
		row = '{reg_sel: REG_CONTINUOUS, default: '0};
		row.is_write = 1'b1;
		row.reg_sel = sel;
		row.value = value;
		return row;
	endfunction

	function automatic stim_row_t tick_row(int target, bit en);
		stim_row_t row;
		row = '{reg_sel: REG_CONTINUOUS, default: '0};
		row.stim.target_current = 16'(target);
		row.stim.amp_enabled = en;
		return row;
	endfunction

	function automatic stim_row_t known_row(int target, bit en, int drive, int lim, bit fold);
		stim_row_t row;
		row = tick_row(target, en);
		row.has_want = 1'b1;
		row.want.drive_current = 16'(drive);
		row.want.present_limit = 15'(lim);
		row.want.foldback_active = fold;
		return row;
	endfunction

	// Mostly a typical value, with each extreme of the range now and then.
	function automatic int pick_level(int lo, int hi, int typical);
		int roll;
		roll = $urandom_range(0, 5);
		if (roll == 0)
			return lo;
		if (roll == 1)
			return hi;
		return typical;
	endfunction

	task automatic write_reg(reg_index_t sel, logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_CONTINUOUS: regs.continuous_current = value[14:0];
			REG_PEAK:       regs.peak_current = value[14:0];
			REG_BUDGET:     regs.budget_ticks = value[15:0];
			REG_SLOPE:      regs.slope_per_tick = value;
			REG_GAIN:       regs.recovery_gain = value;
			REG_CEILING:    regs.counter_ceiling = value[14:0];
			REG_ENABLE:     regs.limit_enable = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Returns at the edge on which the transaction is accepted, with tvalid still high.
	task automatic offer(item_t stim, bit gaps, bit has_want, result_t want);
		result_t predicted;
		if (gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, stim};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ticks_sent++;
		predicted = predict_foldback(stim);
		awaited_outputs.push_back(has_want ? want : predicted);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_out = m_axis_tdata;
			if (awaited_outputs.size() == 0) begin
				$display("%0t: unexpected output transaction, expected none, actual %h",
					$time, m_axis_tdata);
				fail_count++;
			end else begin
				want_out = awaited_outputs.pop_front();
				results_seen++;
				if (got_out.drive_current !== want_out.drive_current) begin
					$display("%0t: drive_current expected %0d, actual %0d",
						$time, want_out.drive_current, got_out.drive_current);
					fail_count++;
				end
				if (got_out.present_limit !== want_out.present_limit) begin
					$display("%0t: present_limit expected %0d, actual %0d",
						$time, want_out.present_limit, got_out.present_limit);
					fail_count++;
				end
				if (got_out.foldback_active !== want_out.foldback_active) begin
					$display("%0t: foldback_active expected %0b, actual %0b",
						$time, want_out.foldback_active, got_out.foldback_active);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding",
				$time, awaited_outputs.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		item_t   stim;
		bit      burst_over;
		int      burst_left;
		int      roll;
		int      mag;
		int      cont_v;
		int      peak_v;
		int      ceil_v;
		bit      gaps;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;

		regs = '{continuous_current: CONT_RST, peak_current: PEAK_RST,
			budget_ticks: BUDGET_RST, slope_per_tick: SLOPE_RST,
			recovery_gain: GAIN_RST, counter_ceiling: CEIL_RST,
			limit_enable: LIMIT_EN_RST};
		fb_active = 1'b0;
		level_q24 = {1'b0, CEIL_RST, 16'd0};
		budget_left = BUDGET_RST;
		limit_q8 = {1'b0, PEAK_RST};

		// Defaults after reset, then leaving and re-entering foldback mid-budget.
		directed_rows.push_back(known_row(0, 1'b1, 0, 5120, 1'b0));
		directed_rows.push_back(known_row(32767, 1'b1, 32767, 5120, 1'b1));
		directed_rows.push_back(known_row(-32768, 1'b0, -32768, 5120, 1'b0));
		directed_rows.push_back(tick_row(-32768, 1'b1));
		directed_rows.push_back(tick_row(-32768, 1'b1));
		directed_rows.push_back(tick_row(2560, 1'b1));
		directed_rows.push_back(tick_row(-2561, 1'b1));
		directed_rows.push_back(tick_row(1, 1'b0));
		// Clamping at both rails.
		directed_rows.push_back(reg_row(REG_ENABLE, 24'd1));
		directed_rows.push_back(tick_row(32767, 1'b1));
		directed_rows.push_back(tick_row(-32768, 1'b1));
		// Steep slope and a low ceiling drive the counter through zero in foldback.
		directed_rows.push_back(reg_row(REG_SLOPE, 24'hFF_FFFF));
		directed_rows.push_back(reg_row(REG_CONTINUOUS, 24'd0));
		directed_rows.push_back(reg_row(REG_CEILING, 24'd100));
		directed_rows.push_back(reg_row(REG_BUDGET, 24'd0));
		directed_rows.push_back(tick_row(0, 1'b0));
		directed_rows.push_back(tick_row(100, 1'b1));
		directed_rows.push_back(tick_row(-100, 1'b1));
		directed_rows.push_back(tick_row(0, 1'b1));
		// Maximum gain overshoots and saturates the counter, then pins it at the ceiling.
		directed_rows.push_back(reg_row(REG_CONTINUOUS, 24'h7FFF));
		directed_rows.push_back(reg_row(REG_CEILING, 24'h7FFF));
		directed_rows.push_back(reg_row(REG_GAIN, 24'hFF_FFFF));
		directed_rows.push_back(reg_row(REG_BUDGET, 24'hFFFF));
		directed_rows.push_back(tick_row(32767, 1'b0));
		directed_rows.push_back(tick_row(-32767, 1'b1));
		directed_rows.push_back(tick_row(-32767, 1'b1));
		directed_rows.push_back(tick_row(0, 1'b1));
		// A zero peak clamps everything to zero.
		directed_rows.push_back(reg_row(REG_PEAK, 24'd0));
		directed_rows.push_back(known_row(12345, 1'b1, 0, 0, 1'b0));
		directed_rows.push_back(known_row(-1, 1'b1, 0, 0, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				drain();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
			end else begin
				offer(directed_rows[i].stim, 1'b1, directed_rows[i].has_want,
					directed_rows[i].want);
			end
		end

		burst_left = 0;
		burst_over = 1'b0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			// The final phase runs at full rate on both sides.
			gaps = (p < RANDOM_PHASES - 1);
			stalls_on = gaps;
			cont_v = pick_level(0, 32767, $urandom_range(256, 6000));
			peak_v = cont_v + $urandom_range(0, 6000);
			peak_v = pick_level(0, 32767, (peak_v > 32767) ? 32767 : peak_v);
			ceil_v = peak_v + $urandom_range(0, 4000);
			ceil_v = pick_level(0, 32767, (ceil_v > 32767) ? 32767 : ceil_v);
			write_reg(REG_CONTINUOUS, 24'(cont_v));
			write_reg(REG_PEAK, 24'(peak_v));
			write_reg(REG_CEILING, 24'(ceil_v));
			write_reg(REG_BUDGET, 24'(pick_level(0, 65535, $urandom_range(1, 60))));
			write_reg(REG_SLOPE, 24'(pick_level(0, 24'hFF_FFFF,
				$urandom_range(1 << 14, 1 << 22))));
			write_reg(REG_GAIN, 24'(pick_level(0, 24'hFF_FFFF,
				$urandom_range(1 << 10, 1 << 20))));
			write_reg(REG_ENABLE, 24'($urandom_range(0, 1)));

			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// Alternate over-current bursts with recovery stretches, with some noise.
				if (burst_left == 0) begin
					burst_over = $urandom_range(0, 1);
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				roll = $urandom_range(0, 99);
				stim.amp_enabled = 1'b1;
				if (roll < 8) begin
					stim.target_current = 16'($urandom);
					stim.amp_enabled = 1'($urandom);
				end else if (roll < 12) begin
					stim.target_current = 16'($urandom);
					stim.amp_enabled = 1'b0;
				end else if (roll < 15) begin
					case ($urandom_range(0, 3))
						0: stim.target_current = 16'sh7FFF;
						1: stim.target_current = 16'sh8000;
						2: stim.target_current = 16'sh0000;
						default: stim.target_current = 16'shFFFF;
					endcase
				end else if (burst_over) begin
					cont_v = regs.continuous_current;
					mag = (cont_v >= 32767) ? 32768 : $urandom_range(32767, cont_v + 1);
					if (mag == 32768 || $urandom_range(0, 1))
						stim.target_current = 16'(-mag);
					else
						stim.target_current = 16'(mag);
				end else begin
					mag = $urandom_range(0, regs.continuous_current);
					stim.target_current = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
				end
				offer(stim, gaps, 1'b0, '0);
			end
		end

		drain();
		$display("Ran %0d ticks (%0d directed, %0d random over %0d register settings).",
			ticks_sent, ticks_sent - RANDOM_PHASES * TICKS_PER_PHASE, RANDOM_PHASES * TICKS_PER_PHASE,
			RANDOM_PHASES);
		$display("Compared %0d output transactions, %0d field mismatches.",
			results_seen, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[amplifier_current_foldback_limiter_core.f]
rtl/core/fbl_pkg.sv
rtl/core/fbl_cfg.sv
rtl/core/fbl_estimator.sv
rtl/core/amplifier_current_foldback_limiter_core.sv
bench/testbench.sv
